[hdl/uartrb_pkg.sv]
// Shared definitions for the serial-port ring buffers: command codes,
// queue status struct, register map and default depths. No dependencies.
package uartrb_pkg;

	localparam int SEND_DEPTH_DEF = 16;
	localparam int RECV_DEPTH_DEF = 16;

	localparam int APB_ADDR_W = 2;
	localparam int APB_DATA_W = 32;

	// register map: byte addresses
	localparam logic [APB_ADDR_W-1:0] ADDR_END_MARK = 2'd0;

	typedef enum logic [2:0] {
		CMD_SEND  = 3'd0,
		CMD_READ  = 3'd1,
		CMD_READY = 3'd2,
		CMD_RECV  = 3'd3,
		CMD_CLEAR = 3'd4
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

[hdl/uartrb_queue.sv]
// Ring buffer of DEPTH bytes holding DEPTH-1 entries, with a prefetched
// head register. Depends on uartrb_pkg.
module uartrb_queue #(
	parameter int DEPTH = uartrb_pkg::SEND_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [7:0]          push_data,
	input  logic                pop,
	output uartrb_pkg::q_stat_t stat,
	output logic [7:0]          head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [7:0]       mem [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W-1:0] wr_inc;
	logic [PTR_W-1:0] rd_inc;
	logic [PTR_W-1:0] rd_next;
	logic [7:0]       head_q;

	assign wr_inc     = (wr_q == LAST) ? '0 : wr_q + 1'b1;
	assign rd_inc     = (rd_q == LAST) ? '0 : rd_q + 1'b1;
	assign rd_next    = pop ? rd_inc : rd_q;
	assign stat.full  = (wr_inc == rd_q);
	assign stat.empty = (wr_q == rd_q);
	assign head       = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_inc;
			end
			if (pop) begin
				rd_q <= rd_inc;
			end
		end
	end

	// head tracks the entry at the read pointer after this cycle; write-first
	// bypass covers a push into the slot about to become the head
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
		if (push && (wr_q == rd_next)) begin
			head_q <= push_data;
		end else begin
			head_q <= mem[rd_next];
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("pop from empty queue");

	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> !stat.full)
		else $error("queue still full after pop");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(wr_q) < DEPTH) && (int'(rd_q) < DEPTH))
		else $error("queue pointer out of range");

endmodule

[hdl/uart_tx_rx_ring_buffers.sv]
// Top level of the serial-port transmit and receive ring buffers: request
// register, command decode, result register and APB register port.
// Depends on uartrb_pkg and uartrb_queue.
//
// Timing: a request accepted into the request register is decoded there, and its
// result register loads when it advances, when out_valid rises; the result is
// taken at an edge where out_valid is high and out_stall is low.
// Throughput: one request per cycle while the result side does not stall.
// Reset (arst_n low): queue pointers zero, transmitter marked idle, end flag
// and end-mark register cleared. Queue contents stay undefined until written;
// there is no clearing pass, so requests are taken straight after reset.
module uart_tx_rx_ring_buffers #(
	parameter int SEND_DEPTH = uartrb_pkg::SEND_DEPTH_DEF,
	parameter int RECV_DEPTH = uartrb_pkg::RECV_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        cmd,
	input  logic [7:0]                        data,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              status,
	output logic [7:0]                        read_data,
	output logic                              tx_valid,
	output logic [7:0]                        tx_byte,
	output logic                              end_seen,
	output logic                              transmitter_idle,
	// APB register port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [uartrb_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [uartrb_pkg::APB_DATA_W-1:0] pwdata,
	output logic [uartrb_pkg::APB_DATA_W-1:0] prdata,
	output logic                              pready
);

	// request register
	logic       valid_s1;
	logic [2:0] cmd_s1;
	logic [7:0] data_s1;

	// result register
	logic       valid_s2;
	logic       status_s2;
	logic [7:0] rdata_s2;
	logic       txv_s2;
	logic [7:0] txb_s2;
	logic       end_s2;
	logic       idle_s2;

	// architectural flags
	logic       idle_q;
	logic       end_q;
	logic [7:0] end_mark_q;

	logic       advance;
	logic       wr_en;

	// queue hooks
	logic                send_push;
	logic                send_pop;
	logic                recv_push;
	logic                recv_pop;
	uartrb_pkg::q_stat_t send_stat;
	uartrb_pkg::q_stat_t recv_stat;
	logic [7:0]          send_head;
	logic [7:0]          recv_head;

	// next-step values from decode
	logic       status_d;
	logic [7:0] rdata_d;
	logic       txv_d;
	logic [7:0] txb_d;
	logic       idle_d;
	logic       end_d;

	// ---------------- handshake ----------------
	// the request in s1 moves on whenever the result slot is free or drains
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1  <= cmd;
			data_s1 <= data;
		end
	end

	// ---------------- command decode ----------------
	// state only changes when the request actually advances, so a stalled
	// request is re-evaluated against unchanged state
	always_comb begin
		status_d  = 1'b0;
		rdata_d   = '0;
		txv_d     = 1'b0;
		txb_d     = '0;
		idle_d    = idle_q;
		end_d     = end_q;
		send_push = 1'b0;
		send_pop  = 1'b0;
		recv_push = 1'b0;
		recv_pop  = 1'b0;
		case (cmd_s1)
			uartrb_pkg::CMD_SEND: begin
				// full check wins over the idle shortcut
				if (send_stat.full) begin
					status_d = 1'b1;
				end else if (idle_q) begin
					txv_d  = 1'b1;
					txb_d  = data_s1;
					idle_d = 1'b0;
				end else begin
					send_push = advance;
				end
			end
			uartrb_pkg::CMD_READ: begin
				if (recv_stat.empty) begin
					status_d = 1'b1;
				end else begin
					rdata_d  = recv_head;
					recv_pop = advance;
				end
			end
			uartrb_pkg::CMD_READY: begin
				if (!send_stat.empty) begin
					txv_d    = 1'b1;
					txb_d    = send_head;
					send_pop = advance;
				end else begin
					idle_d = 1'b1;
				end
			end
			uartrb_pkg::CMD_RECV: begin
				// a dropped byte never reaches the end-mark compare
				if (recv_stat.full) begin
					status_d = 1'b1;
				end else begin
					recv_push = advance;
					if (data_s1 == end_mark_q) begin
						end_d = 1'b1;
					end
				end
			end
			uartrb_pkg::CMD_CLEAR: begin
				end_d = 1'b0;
			end
			default: begin
				// unused codes: no effect, status done
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= 1'b1;
			end_q  <= 1'b0;
		end else if (advance) begin
			idle_q <= idle_d;
			end_q  <= end_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= status_d;
			rdata_s2  <= rdata_d;
			txv_s2    <= txv_d;
			txb_s2    <= txb_d;
			end_s2    <= end_d;
			idle_s2   <= idle_d;
		end
	end

	assign out_valid        = valid_s2;
	assign status           = status_s2;
	assign read_data        = rdata_s2;
	assign tx_valid         = txv_s2;
	assign tx_byte          = txb_s2;
	assign end_seen         = end_s2;
	assign transmitter_idle = idle_s2;

	// ---------------- queues ----------------
	uartrb_queue #(
		.DEPTH (SEND_DEPTH)
	) u_send_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (send_push),
		.push_data (data_s1),
		.pop       (send_pop),
		.stat      (send_stat),
		.head      (send_head)
	);

	uartrb_queue #(
		.DEPTH (RECV_DEPTH)
	) u_recv_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (recv_push),
		.push_data (data_s1),
		.pop       (recv_pop),
		.stat      (recv_stat),
		.head      (recv_head)
	);

	// ---------------- APB register port ----------------
	// single register, zero wait states; other addresses read as zero
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_mark_q <= '0;
		end else if (wr_en && (paddr == uartrb_pkg::ADDR_END_MARK)) begin
			end_mark_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == uartrb_pkg::ADDR_END_MARK) begin
			prdata = {{(uartrb_pkg::APB_DATA_W - 8){1'b0}}, end_mark_q};
		end
	end

endmodule
